// ----- sv/cps_pkg.sv -----
// Shared types, constants and helper functions of the capsule support point pipeline.
// Used by every module of the block; depends on nothing else.
package cps_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    // Configuration register indexes.
    localparam logic REG_RADIUS = 1'b0;
    localparam logic REG_DROP   = 1'b1;

    // Vertex mask codes.
    localparam logic [15:0] MASK_TOP    = 16'h00FF;
    localparam logic [15:0] MASK_BOTTOM = 16'hFF00;
    localparam logic [7:0]  MASK_RING0  = 8'h81;
    localparam logic [7:0]  MASK_PAIR   = 8'hC0;

    // sqrt(1/2) with 32 fractional bits.
    localparam logic [63:0] SQRT_HALF_Q32 = 64'd3037000500;

    typedef logic signed [31:0] q_t;
    typedef q_t [2:0] vec_t;

    // Input item, side in the lowest bits.
    typedef struct packed {
        vec_t dir;
        vec_t depth;
        vec_t up;
        vec_t side;
    } query_t;

    // Dot products and the squared direction length.
    typedef struct packed {
        q_t          dy;
        q_t          hx;
        q_t          hz;
        logic [63:0] mag;
        vec_t        side;
        vec_t        up;
        vec_t        depth;
    } dots_t;

    // Point = side * coef_side + depth * coef_depth + up * coef_up.
    typedef struct packed {
        vec_t               side;
        vec_t               up;
        vec_t               depth;
        logic signed [32:0] coef_side;
        logic signed [32:0] coef_depth;
        logic signed [32:0] coef_up;
        logic [15:0]        mask;
    } coef_t;

    // Result item, point_x in the lowest bits.
    typedef struct packed {
        logic [15:0] mask;
        q_t          z;
        q_t          y;
        q_t          x;
    } result_t;

    // Component of a ring unit vector.
    typedef enum logic [2:0] {
        COMP_ZERO,
        COMP_POS_ONE,
        COMP_NEG_ONE,
        COMP_POS_DIAG,
        COMP_NEG_DIAG
    } comp_t;

    function automatic logic [63:0] diag_q(input int frac);
        diag_q = (SQRT_HALF_Q32 + (64'd1 << (31 - frac))) >> (32 - frac);
    endfunction

    function automatic q_t sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            sat32 = 32'sh7FFFFFFF;
        end else if (v < -66'sd2147483648) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    function automatic comp_t ring_u(input logic [2:0] idx);
        case (idx)
            3'd0:    ring_u = COMP_POS_ONE;
            3'd1:    ring_u = COMP_POS_DIAG;
            3'd2:    ring_u = COMP_ZERO;
            3'd3:    ring_u = COMP_NEG_DIAG;
            3'd4:    ring_u = COMP_NEG_ONE;
            3'd5:    ring_u = COMP_NEG_DIAG;
            3'd6:    ring_u = COMP_ZERO;
            default: ring_u = COMP_POS_DIAG;
        endcase
    endfunction

    function automatic comp_t ring_v(input logic [2:0] idx);
        case (idx)
            3'd0:    ring_v = COMP_ZERO;
            3'd1:    ring_v = COMP_POS_DIAG;
            3'd2:    ring_v = COMP_POS_ONE;
            3'd3:    ring_v = COMP_POS_DIAG;
            3'd4:    ring_v = COMP_ZERO;
            3'd5:    ring_v = COMP_NEG_DIAG;
            3'd6:    ring_v = COMP_NEG_ONE;
            default: ring_v = COMP_NEG_DIAG;
        endcase
    endfunction

endpackage

// ----- sv/cps_dot.sv -----
// Two pipeline stages: the products of the three dot products and the direction
// squares, then their sums, the dot products saturated. Depends on cps_pkg.
module cps_dot #(
    parameter int FRACTION_BITS = cps_pkg::FRACTION_BITS_DEF
) (
    input  logic            aclk,
    input  logic [1:0]      stage_en,
    input  cps_pkg::query_t query,
    output cps_pkg::dots_t  dots
);

    logic signed [63:0] p_up_reg    [3];
    logic signed [63:0] p_side_reg  [3];
    logic signed [63:0] p_depth_reg [3];
    logic [63:0]        sq_reg      [3];
    cps_pkg::vec_t      side_reg, up_reg, depth_reg;
    cps_pkg::dots_t     dots_reg, dots_next;

    logic signed [63:0] p_up_next    [3];
    logic signed [63:0] p_side_next  [3];
    logic signed [63:0] p_depth_next [3];
    logic signed [63:0] sq_next      [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p_up_next[i]    = ($signed(query.up[i]) * $signed(query.dir[i])) >>> FRACTION_BITS;
            p_side_next[i]  = ($signed(query.side[i]) * $signed(query.dir[i])) >>> FRACTION_BITS;
            p_depth_next[i] = ($signed(query.depth[i]) * $signed(query.dir[i]))
                              >>> FRACTION_BITS;
            sq_next[i]      = $signed(query.dir[i]) * $signed(query.dir[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            for (int i = 0; i < 3; i++) begin
                p_up_reg[i]    <= p_up_next[i];
                p_side_reg[i]  <= p_side_next[i];
                p_depth_reg[i] <= p_depth_next[i];
                sq_reg[i]      <= sq_next[i];
            end
            side_reg  <= query.side;
            up_reg    <= query.up;
            depth_reg <= query.depth;
        end
    end

    always_comb begin
        dots_next.dy    = cps_pkg::sat32(66'(p_up_reg[0]) + 66'(p_up_reg[1]) + 66'(p_up_reg[2]));
        dots_next.hx    = cps_pkg::sat32(66'(p_side_reg[0]) + 66'(p_side_reg[1])
                                         + 66'(p_side_reg[2]));
        dots_next.hz    = cps_pkg::sat32(66'(p_depth_reg[0]) + 66'(p_depth_reg[1])
                                         + 66'(p_depth_reg[2]));
        // Each square is at most 2^62, so the sum stays within 64 bits.
        dots_next.mag   = sq_reg[0] + sq_reg[1] + sq_reg[2];
        dots_next.side  = side_reg;
        dots_next.up    = up_reg;
        dots_next.depth = depth_reg;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            dots_reg <= dots_next;
        end
    end

    assign dots = dots_reg;

endmodule

// ----- sv/cps_climb.sv -----
// Three pipeline stages: ring scores, the cap test with the first climb steps,
// then the last climb step and the coefficients of the point. Depends on cps_pkg.
module cps_climb #(
    parameter int FRACTION_BITS = cps_pkg::FRACTION_BITS_DEF
) (
    input  logic           aclk,
    input  logic [2:0]     stage_en,
    input  logic [30:0]    radius,
    input  logic [30:0]    drop_length,
    input  cps_pkg::dots_t dots,
    output cps_pkg::coef_t coef
);

    localparam int PW = FRACTION_BITS + 34;
    localparam int RW = FRACTION_BITS + 33;
    localparam logic signed [FRACTION_BITS:0] DIAG =
        (FRACTION_BITS + 1)'(cps_pkg::diag_q(FRACTION_BITS));

    typedef logic signed [7:0][32:0] scores_t;

    typedef struct packed {
        logic [2:0]         idx;
        logic signed [32:0] cur;
    } climb_t;

    function automatic climb_t climb_step(input scores_t sc, input climb_t c,
                                          input logic [2:0] stride);
        climb_t     r;
        logic [2:0] nxt;
        logic [2:0] prv;
        r   = c;
        nxt = c.idx + stride;
        prv = c.idx - stride;
        if ($signed(sc[nxt]) > r.cur) begin
            r.idx = nxt;
            r.cur = sc[nxt];
        end
        if ($signed(sc[prv]) > r.cur) begin
            r.idx = prv;
            r.cur = sc[prv];
        end
        return r;
    endfunction

    function automatic logic signed [32:0] comp_scale(input cps_pkg::comp_t c,
                                                      input logic [30:0] rad,
                                                      input logic signed [31:0] rdp,
                                                      input logic signed [31:0] rdn);
        case (c)
            cps_pkg::COMP_POS_ONE:  comp_scale = {2'b00, rad};
            cps_pkg::COMP_NEG_ONE:  comp_scale = -$signed({2'b00, rad});
            cps_pkg::COMP_POS_DIAG: comp_scale = {rdp[31], rdp};
            cps_pkg::COMP_NEG_DIAG: comp_scale = {rdn[31], rdn};
            default:                comp_scale = '0;
        endcase
    endfunction

    // First stage: scores of the eight ring directions.
    logic signed [32:0] hsum, hdif;
    logic signed [PW-1:0] pd, pm;
    logic signed [RW-1:0] pr;
    scores_t            sc_next;
    logic [63:0]        dy2_next;

    scores_t            sc_c_reg;
    logic [63:0]        dy2_reg, mag_reg;
    logic               dy_pos_c_reg, dy_neg_c_reg;
    logic signed [31:0] rdp_c_reg, rdn_c_reg;
    cps_pkg::vec_t      side_c_reg, up_c_reg, depth_c_reg;

    always_comb begin
        hsum     = $signed({dots.hx[31], dots.hx}) + $signed({dots.hz[31], dots.hz});
        hdif     = $signed({dots.hx[31], dots.hx}) - $signed({dots.hz[31], dots.hz});
        pd       = DIAG * hsum;
        pm       = DIAG * hdif;
        pr       = DIAG * $signed({1'b0, radius});
        dy2_next = 64'($signed(dots.dy) * $signed(dots.dy));
        sc_next[0] = {dots.hx[31], dots.hx};
        sc_next[1] = 33'(pd >>> FRACTION_BITS);
        sc_next[2] = {dots.hz[31], dots.hz};
        sc_next[3] = 33'((-pm) >>> FRACTION_BITS);
        sc_next[4] = -$signed({dots.hx[31], dots.hx});
        sc_next[5] = 33'((-pd) >>> FRACTION_BITS);
        sc_next[6] = -$signed({dots.hz[31], dots.hz});
        sc_next[7] = 33'(pm >>> FRACTION_BITS);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            sc_c_reg     <= sc_next;
            dy2_reg      <= dy2_next;
            mag_reg      <= dots.mag;
            dy_pos_c_reg <= !dots.dy[31] && (dots.dy != '0);
            dy_neg_c_reg <= dots.dy[31];
            rdp_c_reg    <= 32'(pr >>> FRACTION_BITS);
            rdn_c_reg    <= 32'((-pr) >>> FRACTION_BITS);
            side_c_reg   <= dots.side;
            up_c_reg     <= dots.up;
            depth_c_reg  <= dots.depth;
        end
    end

    // Second stage: cap test, start index and the stride-two step.
    climb_t             start, climb_d_next;
    scores_t            sc_d_reg;
    climb_t             climb_d_reg;
    logic               cap_d_reg, dy_pos_d_reg, dy_neg_d_reg;
    logic signed [31:0] rdp_d_reg, rdn_d_reg;
    cps_pkg::vec_t      side_d_reg, up_d_reg, depth_d_reg;

    always_comb begin
        if (sc_c_reg[0][32]) begin
            start.idx = 3'd4;
            start.cur = sc_c_reg[4];
        end else begin
            start.idx = 3'd0;
            start.cur = sc_c_reg[0];
        end
        climb_d_next = climb_step(sc_c_reg, start, 3'd2);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            sc_d_reg     <= sc_c_reg;
            climb_d_reg  <= climb_d_next;
            cap_d_reg    <= {dy2_reg, 1'b0} > {1'b0, mag_reg};
            dy_pos_d_reg <= dy_pos_c_reg;
            dy_neg_d_reg <= dy_neg_c_reg;
            rdp_d_reg    <= rdp_c_reg;
            rdn_d_reg    <= rdn_c_reg;
            side_d_reg   <= side_c_reg;
            up_d_reg     <= up_c_reg;
            depth_d_reg  <= depth_c_reg;
        end
    end

    // Third stage: stride-one step and the coefficients.
    climb_t         climb_e;
    cps_pkg::coef_t coef_reg, coef_next;
    logic [15:0]    ring_mask;

    always_comb begin
        climb_e = climb_step(sc_d_reg, climb_d_reg, 3'd1);
        if (climb_e.idx == 3'd0) begin
            ring_mask = {8'h00, cps_pkg::MASK_RING0};
        end else begin
            ring_mask = {8'h00, cps_pkg::MASK_PAIR >> (3'd7 - climb_e.idx)};
        end
        coef_next.side  = side_d_reg;
        coef_next.up    = up_d_reg;
        coef_next.depth = depth_d_reg;
        if (cap_d_reg) begin
            coef_next.coef_side  = '0;
            coef_next.coef_depth = '0;
            if (dy_pos_d_reg) begin
                coef_next.coef_up = {2'b00, radius};
                coef_next.mask    = cps_pkg::MASK_TOP;
            end else begin
                coef_next.coef_up = -($signed({2'b00, radius}) + $signed({2'b00, drop_length}));
                coef_next.mask    = cps_pkg::MASK_BOTTOM;
            end
        end else begin
            coef_next.coef_side  = comp_scale(cps_pkg::ring_u(climb_e.idx), radius,
                                              rdp_d_reg, rdn_d_reg);
            coef_next.coef_depth = comp_scale(cps_pkg::ring_v(climb_e.idx), radius,
                                              rdp_d_reg, rdn_d_reg);
            if (dy_neg_d_reg) begin
                coef_next.coef_up = -$signed({2'b00, drop_length});
                coef_next.mask    = ring_mask << 8;
            end else begin
                coef_next.coef_up = '0;
                coef_next.mask    = ring_mask;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

// ----- sv/cps_point.sv -----
// Two pipeline stages: the nine scaled products of the basis vectors, then
// their wrapped sums into the result item. Depends on cps_pkg.
module cps_point #(
    parameter int FRACTION_BITS = cps_pkg::FRACTION_BITS_DEF
) (
    input  logic             aclk,
    input  logic [1:0]       stage_en,
    input  cps_pkg::coef_t   coef,
    output cps_pkg::result_t result
);

    logic signed [64:0] ps_next [3];
    logic signed [64:0] pd_next [3];
    logic signed [64:0] pu_next [3];
    logic [31:0]        ts_reg  [3];
    logic [31:0]        td_reg  [3];
    logic [31:0]        tu_reg  [3];
    logic [15:0]        mask_reg;
    cps_pkg::result_t   result_reg, result_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ps_next[i] = $signed(coef.side[i]) * coef.coef_side;
            pd_next[i] = $signed(coef.depth[i]) * coef.coef_depth;
            pu_next[i] = $signed(coef.up[i]) * coef.coef_up;
        end
    end

    // Only the low 32 bits of each shifted product matter, as the point wraps.
    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            for (int i = 0; i < 3; i++) begin
                ts_reg[i] <= 32'(ps_next[i] >>> FRACTION_BITS);
                td_reg[i] <= 32'(pd_next[i] >>> FRACTION_BITS);
                tu_reg[i] <= 32'(pu_next[i] >>> FRACTION_BITS);
            end
            mask_reg <= coef.mask;
        end
    end

    always_comb begin
        result_next.x    = ts_reg[0] + td_reg[0] + tu_reg[0];
        result_next.y    = ts_reg[1] + td_reg[1] + tu_reg[1];
        result_next.z    = ts_reg[2] + td_reg[2] + tu_reg[2];
        result_next.mask = mask_reg;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ----- sv/capsule_support_point.sv -----
// Capsule support point with an eight-sided ring: seven-stage pipeline.
// Throughput: one item per cycle while m_tready does not stall the output.
// Each stage holds while its successor is full and stalled, so bubbles are filled.
// Reset (aresetn low, synchronous) empties the pipeline and sets radius to 1.0
// and drop_length to 0. Depends on cps_pkg, cps_dot, cps_climb and cps_point.
module capsule_support_point #(
    parameter int FRACTION_BITS = cps_pkg::FRACTION_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // side_x, side_y, side_z, up_x, up_y, up_z, depth_x, depth_y, depth_z,
    // dir_x, dir_y, dir_z (32 bits each)
    input  logic [383:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // point_x, point_y, point_z (32 bits each), vertex_mask (16 bits)
    output logic [111:0] m_tdata,
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [30:0]  cfg_wdata
);

    localparam int STAGES = 7;

    logic [30:0]        radius_reg, drop_reg;
    logic [STAGES-1:0]  valid_reg, valid_next;
    logic [STAGES-1:0]  stage_en;
    cps_pkg::query_t    query;
    cps_pkg::dots_t     dots;
    cps_pkg::coef_t     coef;
    cps_pkg::result_t   result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= 31'd65536;
            drop_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                cps_pkg::REG_RADIUS: radius_reg <= cfg_wdata;
                cps_pkg::REG_DROP:   drop_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or its contents move on.
    always_comb begin
        stage_en[STAGES-1] = !valid_reg[STAGES-1] || m_tready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
        valid_next[0] = stage_en[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < STAGES; i++) begin
            if (stage_en[i]) begin
                valid_next[i] = valid_reg[i-1];
            end else begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign query = s_tdata;

    cps_dot #(.FRACTION_BITS(FRACTION_BITS)) u_dot (
        .aclk     (aclk),
        .stage_en (stage_en[1:0]),
        .query    (query),
        .dots     (dots)
    );

    cps_climb #(.FRACTION_BITS(FRACTION_BITS)) u_climb (
        .aclk        (aclk),
        .stage_en    (stage_en[4:2]),
        .radius      (radius_reg),
        .drop_length (drop_reg),
        .dots        (dots),
        .coef        (coef)
    );

    cps_point #(.FRACTION_BITS(FRACTION_BITS)) u_point (
        .aclk     (aclk),
        .stage_en (stage_en[6:5]),
        .coef     (coef),
        .result   (result)
    );

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[STAGES-1];
    assign m_tdata  = result;

    a_reset_empties: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("pipeline not empty after reset");

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted transfer did not enter the first stage");

    a_mask_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($countones(m_tdata[111:96]) == 2 || $countones(m_tdata[111:96]) == 8))
        else $error("vertex mask has an impossible shape");

    a_mask_one_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && $countones(m_tdata[111:96]) == 2)
            |-> (m_tdata[111:104] == 8'h00 || m_tdata[103:96] == 8'h00))
        else $error("ring vertex mask spans both rings");

endmodule

// ----- dv/tb_capsule_support_point.sv -----
// Testbench for capsule_support_point: drives basis/direction queries over the
// input stream and checks support points and vertex masks against a local predictor.
// Depends on cps_pkg and the capsule_support_point RTL.
module tb_capsule_support_point;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;
    localparam longint ONE_Q = 64'sd1 <<< FB;
    localparam longint DIAG_Q = longint'((64'd3037000500 + (64'd1 << (31 - FB))) >> (32 - FB));
    localparam int CYCLE_LIMIT = 400000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [383:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic         cfg_addr = cps_pkg::REG_RADIUS;
    logic [30:0]  cfg_wdata = '0;

    capsule_support_point dut (.*);

    always #5 aclk = ~aclk;

    logic [383:0] pending_queries[$];
    logic [111:0] expected_points[$];
    longint       radius_q = 65536;
    longint       drop_q = 0;
    int           errors = 0;
    int           cycles = 0;
    bit           quiet_phase = 0;
    int           hold_off = 0;
    bit           stream_on = 0;

    function automatic longint floor_q(input longint v);
        return v >>> FB;
    endfunction

    function automatic longint sat_word(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint dot_q(input longint a[3], input longint b[3]);
        longint s = 0;
        for (int i = 0; i < 3; i++) s += floor_q(a[i] * b[i]);
        return sat_word(s);
    endfunction

    function automatic longint ring_x(input int k);
        case (k & 7)
            0: return ONE_Q;
            1, 7: return DIAG_Q;
            3, 5: return -DIAG_Q;
            4: return -ONE_Q;
            default: return 0;
        endcase
    endfunction

    function automatic longint ring_z(input int k);
        return ring_x(k + 6);
    endfunction

    function automatic longint score_of(input int k, input longint hx, input longint hz);
        return floor_q(ring_x(k) * hx + ring_z(k) * hz);
    endfunction

    function automatic logic [111:0] support_point(input logic [383:0] q);
        longint side[3], up[3], depth[3], dir[3], pt[3];
        longint dy, hx, hz, sc, cur, ns, ps, sx, sz;
        logic [63:0] mag, dy2;
        logic [15:0] mask;
        int idx, nx, pv;
        for (int i = 0; i < 3; i++) begin
            side[i]  = longint'($signed(q[32*i +: 32]));
            up[i]    = longint'($signed(q[32*(3+i) +: 32]));
            depth[i] = longint'($signed(q[32*(6+i) +: 32]));
            dir[i]   = longint'($signed(q[32*(9+i) +: 32]));
        end
        dy = dot_q(up, dir);
        mag = 0;
        for (int i = 0; i < 3; i++) mag += 64'(dir[i] * dir[i]);
        dy2 = 64'(dy * dy);
        // Compared as 64-bit unsigned with wrap, as the squares are computed.
        if (64'(2 * dy2) > mag) begin
            if (dy > 0) begin
                sc = radius_q;
                mask = cps_pkg::MASK_TOP;
            end else begin
                sc = -(radius_q + drop_q);
                mask = cps_pkg::MASK_BOTTOM;
            end
            for (int i = 0; i < 3; i++) pt[i] = floor_q(up[i] * sc);
        end else begin
            hx = dot_q(side, dir);
            hz = dot_q(depth, dir);
            idx = 0;
            cur = score_of(0, hx, hz);
            if (cur < 0) begin
                idx = 4;
                cur = score_of(4, hx, hz);
            end
            for (int st = 2; st >= 1; st--) begin
                nx = (idx + st) & 7;
                pv = (idx + 8 - st) & 7;
                ns = score_of(nx, hx, hz);
                ps = score_of(pv, hx, hz);
                if (ns > cur) begin
                    idx = nx;
                    cur = ns;
                end
                if (ps > cur) begin
                    idx = pv;
                    cur = ps;
                end
            end
            mask = (idx == 0) ? 16'(cps_pkg::MASK_RING0)
                              : 16'(cps_pkg::MASK_PAIR >> (7 - idx));
            sx = floor_q(ring_x(idx) * radius_q);
            sz = floor_q(ring_z(idx) * radius_q);
            for (int i = 0; i < 3; i++) pt[i] = floor_q(side[i] * sx) + floor_q(depth[i] * sz);
            if (dy < 0) begin
                for (int i = 0; i < 3; i++) pt[i] += floor_q(up[i] * (-drop_q));
                mask = mask << 8;
            end
        end
        return {mask, pt[2][31:0], pt[1][31:0], pt[0][31:0]};
    endfunction

    // Driver: offers the head of the queue and predicts on each accepted transfer.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_points.push_back(support_point(s_tdata));
                void'(pending_queries.pop_front());
            end
            if (s_tvalid && !s_tready) begin
                // A transfer on offer stays on offer, unchanged, until it is taken.
            end else if (pending_queries.size() > 0 && stream_on &&
                (quiet_phase || $urandom_range(99) >= 10)) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_queries[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor and receiver stall.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_tdata);
                    errors++;
                end else begin
                    logic [111:0] e;
                    e = expected_points.pop_front();
                    for (int f = 0; f < 4; f++) begin
                        if (f < 3 && e[32*f +: 32] !== m_tdata[32*f +: 32]) begin
                            $display("%0t: point field %0d expected %h actual %h",
                                     $time, f, e[32*f +: 32], m_tdata[32*f +: 32]);
                            errors++;
                        end
                    end
                    if (e[111:96] !== m_tdata[111:96]) begin
                        $display("%0t: vertex_mask expected %h actual %h",
                                 $time, e[111:96], m_tdata[111:96]);
                        errors++;
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= quiet_phase || $urandom_range(99) >= 10;
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL capsule_support_point");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word(input int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(262144)) - 131072);
            2: return 32'h80000000;
            3: return 32'h7FFFFFFF;
            default: return '0;
        endcase
    endfunction

    task automatic write_reg(input logic idx, input logic [30:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == cps_pkg::REG_RADIUS) radius_q = longint'(val);
        else drop_q = longint'(val);
    endtask

    task automatic run_phase();
        stream_on = 1;
        wait (pending_queries.size() == 0 && !s_tvalid);
        wait (expected_points.size() == 0);
        stream_on = 0;
        repeat (12) @(posedge aclk);
    endtask

    task automatic add_query(input logic [383:0] q);
        pending_queries.push_back(q);
    endtask

    function automatic logic [383:0] random_query(input int bias);
        logic [383:0] q;
        int mode;
        for (int i = 0; i < 12; i++) begin
            mode = (bias == 0) ? $urandom_range(9) : bias;
            q[32*i +: 32] = rand_word(mode < 6 ? 1 : (mode < 8 ? 0 : mode - 6));
        end
        return q;
    endfunction

    initial begin
        logic [383:0] q;
        logic [30:0] radii[5];
        logic [30:0] drops[5];
        radii = '{31'h10000, 31'h0, 31'h7FFFFFFF, 31'h28000, 31'h1234};
        drops = '{31'h0, 31'h7FFFFFFF, 31'h0, 31'h30000, 31'h5A5A5};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: identity basis with directions covering both caps, every ring
        // vertex on both rings, a zero direction and full-scale saturating values.
        for (int k = 0; k < 8; k++) begin
            for (int lo = 0; lo < 2; lo++) begin
                q = '0;
                q[31:0] = 32'h10000;
                q[32*4 +: 32] = 32'h10000;
                q[32*8 +: 32] = 32'h10000;
                q[32*9 +: 32] = 32'(ring_x(k) * 3);
                q[32*11 +: 32] = 32'(ring_z(k) * 3);
                q[32*10 +: 32] = lo ? 32'hFFFF8000 : 32'h00008000;
                add_query(q);
            end
        end
        q = '0;
        q[32*4 +: 32] = 32'h10000;
        q[32*10 +: 32] = 32'h20000;
        add_query(q);
        q[32*10 +: 32] = 32'hFFFE0000;
        add_query(q);
        add_query('0);
        add_query({12{32'h80000000}});
        add_query({12{32'h7FFFFFFF}});
        add_query({6{32'h80000000, 32'h7FFFFFFF}});
        add_query({384{1'b1}});
        run_phase();

        for (int ph = 0; ph < 5; ph++) begin
            write_reg(cps_pkg::REG_RADIUS, radii[ph]);
            write_reg(cps_pkg::REG_DROP, drops[ph]);
            quiet_phase = (ph == 2);
            for (int n = 0; n < 210; n++) add_query(random_query(n < 10 ? 8 + n % 2 : 0));
            // The receiver holds off long enough for the pipeline to fill and stall.
            if (ph == 1) hold_off = 60;
            run_phase();
        end

        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS capsule_support_point");
        end else begin
            $display("FAIL capsule_support_point");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
sv/cps_pkg.sv
sv/cps_dot.sv
sv/cps_climb.sv
sv/cps_point.sv
sv/capsule_support_point.sv
dv/tb_capsule_support_point.sv
